// ----- rtl/pbpf_pkg.sv -----
// ----------------------------------------------------------------------------
// pbpf_pkg: shared types and constants for the pi branch power flow block
// Register indexes, default widths and derived datapath widths.
// ----------------------------------------------------------------------------
package pbpf_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 24;
    localparam int NUM_REGS   = 6;
    localparam int CFG_ADDR_W = 3;
    localparam int LANES      = 4;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_Z_RE,
        REG_Z_IM,
        REG_Y1_RE,
        REG_Y1_IM,
        REG_Y2_RE,
        REG_Y2_IM
    } cfg_reg_t;

    typedef struct packed {
        logic neg;
        logic ovf;
        logic rem_nz;
    } lane_flag_t;

    // shunt product |V|^2 * Y
    function automatic int f_pw(int dw);
        return 3 * dw + 1;
    endfunction

    // rounded shunt term
    function automatic int f_sw(int dw, int fw);
        return 3 * dw + 1 - 2 * fw;
    endfunction

    // flow numerator 2n + den
    function automatic int f_nnw(int dw);
        return 3 * dw + 5;
    endfunction

    // divisor 2 |Z|^2
    function automatic int f_ddw(int dw);
        return 2 * dw + 1;
    endfunction

    // quotient bits; clamp range dominates any shunt term
    function automatic int f_qb(int dw, int fw);
        return ((f_sw(dw, fw) > dw) ? f_sw(dw, fw) : dw) + 2;
    endfunction

    function automatic int f_sidew(int dw, int fw);
        return 6 * f_sw(dw, fw) + 3;
    endfunction

endpackage

// ----- rtl/pbpf_front.sv -----
// ----------------------------------------------------------------------------
// pbpf_front: product pipeline
// Eight stages: squares, cross products, V conj(D), split products, flow
// numerators, shunt rounding. Hands numerators and divisor to the divider.
// ----------------------------------------------------------------------------
module pbpf_front #(
    parameter int DW = pbpf_pkg::DATA_WIDTH,
    parameter int FW = pbpf_pkg::FRAC_BITS
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    en,
    input  logic                                    in_valid,
    input  logic signed [DW-1:0]                    in_volt [pbpf_pkg::LANES],
    input  logic signed [DW-1:0]                    cfg_val [pbpf_pkg::NUM_REGS],
    output logic                                    out_valid,
    output logic signed [pbpf_pkg::f_nnw(DW)-1:0]   out_num [pbpf_pkg::LANES],
    output logic [pbpf_pkg::f_ddw(DW)-1:0]          out_dsor,
    output logic signed [pbpf_pkg::f_sw(DW,FW)-1:0] out_shunt [pbpf_pkg::LANES],
    output logic signed [pbpf_pkg::f_sw(DW,FW):0]   out_total [2],
    output logic                                    out_zflag
);
    import pbpf_pkg::*;

    localparam int MW  = 2 * DW + 2;
    localparam int PW  = f_pw(DW);
    localparam int PTW = PW + 1;
    localparam int MZW = MW + DW;
    localparam int NW  = MZW + 1;
    localparam int NNW = f_nnw(DW);
    localparam int DDW = f_ddw(DW);
    localparam int SW  = f_sw(DW, FW);
    localparam int STW = SW + 1;
    localparam int RND = 2 * FW;

    logic [7:0] v_reg;

    logic signed [DW-1:0]     v0_reg [4];
    logic signed [DW-1:0]     v1_reg [4];
    logic signed [2*DW-1:0]   sq_reg [4];
    logic signed [2*DW-1:0]   zsq_reg [2];
    logic signed [DW:0]       d_reg [2];
    logic signed [2*DW:0]     mag2_reg [2];
    logic signed [2*DW:0]     mag3_reg [2];
    logic signed [2*DW:0]     den2_reg, den3_reg, den4_reg, den5_reg, den6_reg;
    logic signed [2*DW:0]     cr_reg [8];
    logic signed [MW-1:0]     m_reg [4];
    logic signed [2*DW:0]     pm_lo_reg [4];
    logic signed [2*DW:0]     pm_hi_reg [4];
    logic signed [2*DW+1:0]   pz_lo_reg [8];
    logic signed [2*DW+1:0]   pz_hi_reg [8];
    logic signed [PW-1:0]     pmag_reg [4];
    logic signed [MZW-1:0]    pmz_reg [8];
    logic signed [NW-1:0]     n_reg [4];
    logic signed [PW-1:0]     psh_reg [4];
    logic signed [PTW-1:0]    ptot_reg [2];
    logic signed [NNW-1:0]    num_reg [4];
    logic [DDW-1:0]           dsor_reg;
    logic                     z_reg;
    logic signed [SW-1:0]     sh_reg [4];
    logic signed [STW-1:0]    tot_reg [2];

    logic signed [2*DW:0]     pm_lo_c [4];
    logic signed [2*DW:0]     pm_hi_c [4];
    logic signed [2*DW+1:0]   pz_lo_c [8];
    logic signed [2*DW+1:0]   pz_hi_c [8];
    logic [PW-1:0]            sh_sum [4];
    logic [PTW-1:0]           tot_sum [2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[6:0], in_valid};
        end
    end

    // split multiplies: low word unsigned, high word signed
    for (genvar k = 0; k < 4; k++) begin : g_mag
        logic signed [DW:0] lo, hi;
        assign lo = $signed({1'b0, mag3_reg[k>>1][DW-1:0]});
        assign hi = $signed(mag3_reg[k>>1][2*DW:DW]);
        assign pm_lo_c[k] = (2*DW+1)'(lo) * (2*DW+1)'(cfg_val[int'(REG_Y1_RE) + k]);
        assign pm_hi_c[k] = (2*DW+1)'(hi) * (2*DW+1)'(cfg_val[int'(REG_Y1_RE) + k]);
    end

    for (genvar j = 0; j < 8; j++) begin : g_mz
        localparam int L  = j >> 1;
        localparam int T  = j & 1;
        localparam int MI = 2 * (L >> 1) + T;
        localparam int ZI = ((L & 1) != T) ? 1 : 0;
        logic signed [DW:0]   lo;
        logic signed [DW+1:0] hi;
        assign lo = $signed({1'b0, m_reg[MI][DW-1:0]});
        assign hi = $signed(m_reg[MI][MW-1:DW]);
        assign pz_lo_c[j] = (2*DW+2)'(lo) * (2*DW+2)'(cfg_val[int'(REG_Z_RE) + ZI]);
        assign pz_hi_c[j] = (2*DW+2)'(hi) * (2*DW+2)'(cfg_val[int'(REG_Z_RE) + ZI]);
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            sh_sum[k] = PW'(psh_reg[k]) + (PW'(1) << (RND - 1));
        end
        for (int t = 0; t < 2; t++) begin
            tot_sum[t] = PTW'(ptot_reg[t]) + (PTW'(1) << (RND - 1));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v0_reg <= in_volt;

            v1_reg <= v0_reg;
            for (int k = 0; k < 4; k++) begin
                sq_reg[k] <= (2*DW)'(v0_reg[k]) * (2*DW)'(v0_reg[k]);
            end
            zsq_reg[0] <= (2*DW)'(cfg_val[REG_Z_RE]) * (2*DW)'(cfg_val[REG_Z_RE]);
            zsq_reg[1] <= (2*DW)'(cfg_val[REG_Z_IM]) * (2*DW)'(cfg_val[REG_Z_IM]);
            d_reg[0] <= (DW+1)'(v0_reg[0]) - (DW+1)'(v0_reg[2]);
            d_reg[1] <= (DW+1)'(v0_reg[1]) - (DW+1)'(v0_reg[3]);

            for (int e = 0; e < 2; e++) begin
                mag2_reg[e] <= (2*DW+1)'(sq_reg[2*e]) + (2*DW+1)'(sq_reg[2*e+1]);
                cr_reg[4*e]   <= (2*DW+1)'(v1_reg[2*e])   * (2*DW+1)'(d_reg[0]);
                cr_reg[4*e+1] <= (2*DW+1)'(v1_reg[2*e+1]) * (2*DW+1)'(d_reg[1]);
                cr_reg[4*e+2] <= (2*DW+1)'(v1_reg[2*e+1]) * (2*DW+1)'(d_reg[0]);
                cr_reg[4*e+3] <= (2*DW+1)'(v1_reg[2*e])   * (2*DW+1)'(d_reg[1]);
            end
            den2_reg <= (2*DW+1)'(zsq_reg[0]) + (2*DW+1)'(zsq_reg[1]);

            // end two sees D negated
            m_reg[0] <= MW'(cr_reg[0]) + MW'(cr_reg[1]);
            m_reg[1] <= MW'(cr_reg[2]) - MW'(cr_reg[3]);
            m_reg[2] <= -(MW'(cr_reg[4]) + MW'(cr_reg[5]));
            m_reg[3] <= MW'(cr_reg[7]) - MW'(cr_reg[6]);
            mag3_reg <= mag2_reg;
            den3_reg <= den2_reg;

            pm_lo_reg <= pm_lo_c;
            pm_hi_reg <= pm_hi_c;
            pz_lo_reg <= pz_lo_c;
            pz_hi_reg <= pz_hi_c;
            den4_reg  <= den3_reg;

            for (int k = 0; k < 4; k++) begin
                pmag_reg[k] <= (PW'(pm_hi_reg[k]) <<< DW) + PW'(pm_lo_reg[k]);
            end
            for (int j = 0; j < 8; j++) begin
                pmz_reg[j] <= (MZW'(pz_hi_reg[j]) <<< DW) + MZW'(pz_lo_reg[j]);
            end
            den5_reg <= den4_reg;

            for (int l = 0; l < 4; l++) begin
                if ((l & 1) == 0) begin
                    n_reg[l] <= NW'(pmz_reg[2*l]) - NW'(pmz_reg[2*l+1]);
                end else begin
                    n_reg[l] <= NW'(pmz_reg[2*l]) + NW'(pmz_reg[2*l+1]);
                end
            end
            psh_reg[0]  <= pmag_reg[0];
            psh_reg[1]  <= -pmag_reg[1];
            psh_reg[2]  <= pmag_reg[2];
            psh_reg[3]  <= -pmag_reg[3];
            ptot_reg[0] <= PTW'(pmag_reg[0]) + PTW'(pmag_reg[2]);
            ptot_reg[1] <= -(PTW'(pmag_reg[1]) + PTW'(pmag_reg[3]));
            den6_reg    <= den5_reg;

            for (int l = 0; l < 4; l++) begin
                num_reg[l] <= (NNW'(n_reg[l]) <<< 1) + NNW'(den6_reg);
                sh_reg[l]  <= $signed(sh_sum[l][PW-1:RND]);
            end
            for (int t = 0; t < 2; t++) begin
                tot_reg[t] <= $signed(tot_sum[t][PTW-1:RND]);
            end
            dsor_reg <= {den6_reg[2*DW-1:0], 1'b0};
            z_reg    <= (den6_reg == '0);
        end
    end

    assign out_valid = v_reg[7];
    assign out_num   = num_reg;
    assign out_dsor  = dsor_reg;
    assign out_shunt = sh_reg;
    assign out_total = tot_reg;
    assign out_zflag = z_reg;

endmodule

// ----- rtl/pbpf_div.sv -----
// ----------------------------------------------------------------------------
// pbpf_div: pipelined restoring divider, four lanes
// One quotient bit per stage on |N| / D, with an overflow flag when the quotient
// does not fit. Side data travels alongside.
// ----------------------------------------------------------------------------
module pbpf_div #(
    parameter int DW    = pbpf_pkg::DATA_WIDTH,
    parameter int FW    = pbpf_pkg::FRAC_BITS,
    parameter int SIDEW = pbpf_pkg::f_sidew(DW, FW)
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic signed [pbpf_pkg::f_nnw(DW)-1:0] in_num [pbpf_pkg::LANES],
    input  logic [pbpf_pkg::f_ddw(DW)-1:0]        in_dsor,
    input  logic [SIDEW-1:0]                      in_side,
    output logic                                  out_valid,
    output logic [pbpf_pkg::f_qb(DW,FW)-1:0]      out_quo [pbpf_pkg::LANES],
    output pbpf_pkg::lane_flag_t                  out_flag [pbpf_pkg::LANES],
    output logic [SIDEW-1:0]                      out_side
);
    import pbpf_pkg::*;

    localparam int NNW = f_nnw(DW);
    localparam int DDW = f_ddw(DW);
    localparam int QB  = f_qb(DW, FW);
    localparam int UW  = NNW - QB;
    localparam int CW  = (UW > DDW) ? UW : DDW;

    logic [QB:0]      v_reg;
    logic [DDW-1:0]   rem_reg  [0:QB][LANES];
    logic [QB-1:0]    low_reg  [0:QB][LANES];
    lane_flag_t       flag_reg [0:QB][LANES];
    logic [SIDEW-1:0] side_reg [0:QB];

    logic [NNW-1:0]   abs_c  [LANES];
    logic [CW-1:0]    upx_c  [LANES];
    lane_flag_t       flag_c [LANES];
    logic [DDW-1:0]   rem_n  [1:QB][LANES];
    logic [QB-1:0]    low_n  [1:QB][LANES];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            abs_c[l] = in_num[l][NNW-1] ? NNW'(-in_num[l]) : NNW'(in_num[l]);
            upx_c[l] = CW'(abs_c[l][NNW-1:QB]);
            flag_c[l].neg    = in_num[l][NNW-1];
            flag_c[l].ovf    = (upx_c[l] >= CW'(in_dsor));
            flag_c[l].rem_nz = 1'b0;
        end
    end

    always_comb begin
        logic [DDW:0] r2;
        logic         ge;
        for (int s = 1; s <= QB; s++) begin
            for (int l = 0; l < LANES; l++) begin
                r2 = {rem_reg[s-1][l], low_reg[s-1][l][QB-1]};
                ge = (r2 >= {1'b0, in_dsor});
                rem_n[s][l] = ge ? DDW'(r2 - {1'b0, in_dsor}) : r2[DDW-1:0];
                low_n[s][l] = {low_reg[s-1][l][QB-2:0], ge};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[QB-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < LANES; l++) begin
                rem_reg[0][l]  <= upx_c[l][DDW-1:0];
                low_reg[0][l]  <= abs_c[l][QB-1:0];
                flag_reg[0][l] <= flag_c[l];
            end
            side_reg[0] <= in_side;
            for (int s = 1; s <= QB; s++) begin
                for (int l = 0; l < LANES; l++) begin
                    rem_reg[s][l]  <= rem_n[s][l];
                    low_reg[s][l]  <= low_n[s][l];
                    flag_reg[s][l] <= flag_reg[s-1][l];
                end
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            out_quo[l]         = low_reg[QB][l];
            out_flag[l].neg    = flag_reg[QB][l].neg;
            out_flag[l].ovf    = flag_reg[QB][l].ovf;
            out_flag[l].rem_nz = (rem_reg[QB][l] != '0);
        end
    end

    assign out_valid = v_reg[QB];
    assign out_side  = side_reg[QB];

endmodule

// ----- rtl/pbpf_out.sv -----
// ----------------------------------------------------------------------------
// pbpf_out: flow rounding, injection sums, saturation and output stage
// Floors the signed quotients, adds shunt terms, clamps to the data width
// and drives the result channel through an output register and skid slot.
// ----------------------------------------------------------------------------
module pbpf_out #(
    parameter int DW = pbpf_pkg::DATA_WIDTH,
    parameter int FW = pbpf_pkg::FRAC_BITS
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    in_valid,
    input  logic [pbpf_pkg::f_qb(DW,FW)-1:0]        in_quo [pbpf_pkg::LANES],
    input  pbpf_pkg::lane_flag_t                    in_flag [pbpf_pkg::LANES],
    input  logic signed [pbpf_pkg::f_sw(DW,FW)-1:0] in_shunt [pbpf_pkg::LANES],
    input  logic signed [pbpf_pkg::f_sw(DW,FW):0]   in_total [2],
    input  logic                                    in_zflag,
    output logic                                    en,
    input  logic                                    m_ready,
    output logic                                    m_valid,
    output logic [6*DW-1:0]                         m_data,
    output logic [1:0]                              m_user
);
    import pbpf_pkg::*;

    localparam int QB   = f_qb(DW, FW);
    localparam int SW   = f_sw(DW, FW);
    localparam int STW  = SW + 1;
    localparam int FLW  = QB + 1;
    localparam int SUMW = QB + 2;

    logic signed [FLW-1:0]  flow_c   [LANES];
    logic signed [FLW-1:0]  flow_reg [LANES];
    logic signed [SW-1:0]   sh_reg   [LANES];
    logic signed [STW-1:0]  tot_reg  [2];
    logic                   z_reg;
    logic                   v1_reg;

    logic signed [SUMW-1:0] val_c [6];
    logic [5:0]             ok_c;
    logic [6*DW-1:0]        res_data;
    logic [1:0]             res_user;

    logic                   m_valid_reg;
    logic [6*DW-1:0]        m_data_reg;
    logic [1:0]             m_user_reg;
    logic                   skid_valid_reg;
    logic [6*DW-1:0]        skid_data_reg;
    logic [1:0]             skid_user_reg;

    assign en = !skid_valid_reg;

    // floor of signed quotient; clamped lanes keep sign and exceed any sum; zero impedance gives zero
    always_comb begin
        logic signed [FLW-1:0] qe;
        for (int l = 0; l < LANES; l++) begin
            qe = $signed(FLW'(in_quo[l]))
               + $signed(FLW'(in_flag[l].neg & in_flag[l].rem_nz));
            if (in_zflag) begin
                flow_c[l] = '0;
            end else if (in_flag[l].ovf) begin
                flow_c[l] = in_flag[l].neg ? $signed({1'b1, {QB{1'b0}}})
                                           : $signed({1'b0, {QB{1'b1}}});
            end else begin
                flow_c[l] = in_flag[l].neg ? -qe : qe;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            flow_reg <= flow_c;
            sh_reg   <= in_shunt;
            tot_reg  <= in_total;
            z_reg    <= in_zflag;
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            val_c[k] = SUMW'(sh_reg[k]) + SUMW'(flow_reg[k]);
        end
        val_c[4] = SUMW'(tot_reg[0]);
        val_c[5] = SUMW'(tot_reg[1]);
        for (int k = 0; k < 6; k++) begin
            ok_c[k] = (&val_c[k][SUMW-1:DW-1]) || !(|val_c[k][SUMW-1:DW-1]);
            if (ok_c[k]) begin
                res_data[k*DW +: DW] = val_c[k][DW-1:0];
            end else if (val_c[k][SUMW-1]) begin
                res_data[k*DW +: DW] = {1'b1, {(DW-1){1'b0}}};
            end else begin
                res_data[k*DW +: DW] = {1'b0, {(DW-1){1'b1}}};
            end
        end
        res_user = {z_reg, !(&ok_c)};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!skid_valid_reg) begin
            if (v1_reg && m_valid_reg && !m_ready) begin
                skid_valid_reg <= 1'b1;
            end else if (!m_valid_reg || m_ready) begin
                m_valid_reg <= v1_reg;
            end
        end else if (m_ready) begin
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!skid_valid_reg) begin
            if (m_valid_reg && !m_ready) begin
                skid_data_reg <= res_data;
                skid_user_reg <= res_user;
            end else begin
                m_data_reg <= res_data;
                m_user_reg <= res_user;
            end
        end else if (m_ready) begin
            m_data_reg <= skid_data_reg;
            m_user_reg <= skid_user_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign m_user  = m_user_reg;

endmodule

// ----- rtl/pi_branch_power_flow_top.sv -----
// ----------------------------------------------------------------------------
// pi_branch_power_flow_top: complex power flow through a pi branch
// Throughput: one item per cycle while the skid slot is empty; s_tready
//   drops while it holds a beat. The divider has 51 bit stages at the
//   default widths; its one-bit-per-stage chain sets the depth.
// Reset: config registers return to Z = j1.0, Y1 = Y2 = 0; pipeline emptied.
// ----------------------------------------------------------------------------
module pi_branch_power_flow_top #(
    parameter int DATA_WIDTH = pbpf_pkg::DATA_WIDTH,
    parameter int FRAC_BITS  = pbpf_pkg::FRAC_BITS
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // volt_one_real, volt_one_imag, volt_two_real, volt_two_imag
    input  logic [((4*DATA_WIDTH+7)/8)*8-1:0]     s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // inject_one_real, inject_one_imag, inject_two_real, inject_two_imag,
    // shunt_total_real, shunt_total_imag
    output logic [((6*DATA_WIDTH+7)/8)*8-1:0]     m_tdata,
    // overflow_flag, zero_impedance_flag
    output logic [1:0]                            m_tuser,
    input  logic                                  cfg_we,
    input  logic [pbpf_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [DATA_WIDTH-1:0]                 cfg_wdata
);
    import pbpf_pkg::*;

    localparam int DW      = DATA_WIDTH;
    localparam int FW      = FRAC_BITS;
    localparam int NNW     = f_nnw(DW);
    localparam int DDW     = f_ddw(DW);
    localparam int SW      = f_sw(DW, FW);
    localparam int STW     = SW + 1;
    localparam int QB      = f_qb(DW, FW);
    localparam int SIDEW   = f_sidew(DW, FW);
    localparam int OUT_TDW = ((6*DW+7)/8)*8;

    logic signed [DW-1:0]  cfg_reg [NUM_REGS];
    logic signed [DW-1:0]  volt [LANES];

    logic                  en;
    logic                  fr_valid;
    logic signed [NNW-1:0] fr_num [LANES];
    logic [DDW-1:0]        fr_dsor;
    logic signed [SW-1:0]  fr_shunt [LANES];
    logic signed [STW-1:0] fr_total [2];
    logic                  fr_zflag;
    logic [SIDEW-1:0]      side_in, side_out;

    logic                  dv_valid;
    logic [QB-1:0]         dv_quo [LANES];
    lane_flag_t            dv_flag [LANES];
    logic signed [SW-1:0]  dv_shunt [LANES];
    logic signed [STW-1:0] dv_total [2];

    logic [6*DW-1:0]       out_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                cfg_reg[i] <= '0;
            end
            cfg_reg[REG_Z_IM] <= DW'(1) << FW;
        end else if (cfg_we && (cfg_addr < CFG_ADDR_W'(NUM_REGS))) begin
            cfg_reg[cfg_addr] <= cfg_wdata;
        end
    end

    for (genvar k = 0; k < LANES; k++) begin : g_in
        assign volt[k] = $signed(s_tdata[k*DW +: DW]);
    end

    pbpf_front #(.DW(DW), .FW(FW)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_volt   (volt),
        .cfg_val   (cfg_reg),
        .out_valid (fr_valid),
        .out_num   (fr_num),
        .out_dsor  (fr_dsor),
        .out_shunt (fr_shunt),
        .out_total (fr_total),
        .out_zflag (fr_zflag)
    );

    for (genvar k = 0; k < LANES; k++) begin : g_side
        assign side_in[k*SW +: SW] = fr_shunt[k];
        assign dv_shunt[k]         = $signed(side_out[k*SW +: SW]);
    end
    for (genvar t = 0; t < 2; t++) begin : g_tot
        assign side_in[LANES*SW + t*STW +: STW] = fr_total[t];
        assign dv_total[t] = $signed(side_out[LANES*SW + t*STW +: STW]);
    end
    assign side_in[SIDEW-1] = fr_zflag;

    pbpf_div #(.DW(DW), .FW(FW), .SIDEW(SIDEW)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fr_valid),
        .in_num    (fr_num),
        .in_dsor   (fr_dsor),
        .in_side   (side_in),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_flag  (dv_flag),
        .out_side  (side_out)
    );

    pbpf_out #(.DW(DW), .FW(FW)) u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (dv_valid),
        .in_quo   (dv_quo),
        .in_flag  (dv_flag),
        .in_shunt (dv_shunt),
        .in_total (dv_total),
        .in_zflag (side_out[SIDEW-1]),
        .en       (en),
        .m_ready  (m_tready),
        .m_valid  (m_tvalid),
        .m_data   (out_data),
        .m_user   (m_tuser)
    );

    assign s_tready = en;
    assign m_tdata  = OUT_TDW'(out_data);

endmodule
